FILE: rtl/bdas_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bdas_pkg
// Constants, register indexes and the arctangent table of the aim solver.
// ----------------------------------------------------------------------------
package bdas_pkg;

  typedef enum logic [2:0] {
    REG_OFFSET_X   = 3'd0,
    REG_OFFSET_Y   = 3'd1,
    REG_OFFSET_Z   = 3'd2,
    REG_PITCH_TRIM = 3'd3,
    REG_YAW_TRIM   = 3'd4,
    REG_DRAG_COEFF = 3'd5,
    REG_SPEED      = 3'd6
  } cfg_reg_e;

  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgDataW = 18;

  // ceil(2^43 / 625): magnitude times this, shifted right by 31, is mag*4096/625
  localparam logic [63:0] MM10_RECIP = 64'd14073748836;
  localparam logic [63:0] TRIM_MUL = 64'd205887;
  localparam logic [63:0] TRIM_RND = 64'd9000;
  // ceil(2^48 / 18000): product shifted right by 48 is the quotient
  localparam logic [63:0] TRIM_RECIP = 64'd15637498707;
  localparam logic [14:0] SPEED_RESET = 15'd3840;

  localparam logic signed [21:0] HALF_PI_Q16 = 22'sd102944;
  localparam logic signed [47:0] CORDIC_GAIN_Q30 = 48'sd652032874;
  localparam logic [63:0] GRAV_Q16 = 64'd640942;
  localparam logic [26:0] T_SAT = 27'd67108864;
  localparam logic [63:0] U_SAT = 64'd60129542144;
  localparam logic [63:0] U_HALF = 64'd268435456;
  localparam logic [63:0] D_SAT = 64'd68719476736;
  localparam logic [63:0] TWO_Q32 = 64'd8589934592;
  localparam logic [47:0] NORM_MIN = 48'd1099511627776;
  localparam logic signed [43:0] AIM_SAT = 44'sd1099511627776;
  localparam logic signed [22:0] ANGLE_SAT = 23'sd411775;
  localparam logic signed [42:0] TOL_Q16 = 43'sd65;
  localparam logic [4:0] CORDIC_LAST = 5'd16;

  function automatic logic [16:0] atan_tab(input logic [4:0] idx);
    logic [16:0] v;
    case (idx)
      5'd0:  v = 17'd51472;
      5'd1:  v = 17'd30386;
      5'd2:  v = 17'd16055;
      5'd3:  v = 17'd8150;
      5'd4:  v = 17'd4091;
      5'd5:  v = 17'd2047;
      5'd6:  v = 17'd1024;
      5'd7:  v = 17'd512;
      5'd8:  v = 17'd256;
      5'd9:  v = 17'd128;
      5'd10: v = 17'd64;
      5'd11: v = 17'd32;
      5'd12: v = 17'd16;
      5'd13: v = 17'd8;
      5'd14: v = 17'd4;
      5'd15: v = 17'd2;
      5'd16: v = 17'd1;
      default: v = 17'd0;
    endcase
    return v;
  endfunction

  // ceil(2^32 / n) for the Taylor term divisors; product shifted right by 32
  function automatic logic [63:0] tay_recip(input logic [2:0] n);
    logic [63:0] v;
    case (n)
      3'd2:    v = 64'd2147483648;
      3'd3:    v = 64'd1431655766;
      3'd4:    v = 64'd1073741824;
      3'd5:    v = 64'd858993460;
      default: v = 64'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/ballistic_drag_aim_solver.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ballistic_drag_aim_solver
// Gimbal pitch and yaw for one target position, with a linear-drag bullet
// model solved by aim-height iteration on one shared CORDIC, multiply and
// divide datapath.
//
//   channel  signals                                         direction
//   in       in_valid_i/in_ready_o, target_x/y/z_i           to block
//   out      out_valid_o/out_ready_i, pitch/yaw, converged   from block
//   cfg      cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i to block
//
// One beat in runs a setup, longer with drag on, then the aim iterations and
// the yaw solve; the 64-step radix-2 divider, the 17-step CORDIC and operand
// normalization set how long each part takes.
// in_ready_o is high only while the sequencer is idle.
// The result sits in an output register; a stalled output holds the sequencer
// at its last step only when that register is still full.
// Reset loads the register defaults and empties the output register.
// ----------------------------------------------------------------------------
module ballistic_drag_aim_solver #(
  parameter int unsigned MAX_ITERATIONS = 20
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic signed [20:0]             target_x_i,
  input  wire logic signed [20:0]             target_y_i,
  input  wire logic signed [20:0]             target_z_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic signed [19:0]                  pitch_angle_o,
  output logic signed [19:0]                  yaw_angle_o,
  output logic                                converged_o,
  output logic [6:0]                          iterations_used_o,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [bdas_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [bdas_pkg::CfgDataW-1:0]  cfg_data_i
);
  import bdas_pkg::*;

  typedef enum logic [5:0] {
    ST_IDLE, ST_CONV, ST_CONV_DONE, ST_TRIM, ST_TRIM_DIV, ST_TRIM_DONE,
    ST_START, ST_DRAG_U, ST_HALVE, ST_TAY_MUL, ST_TAY_DIV, ST_TAY_ADD,
    ST_SQ, ST_SQ_DONE, ST_DDIV_DONE, ST_ITER, ST_IT_SC, ST_IT_VC, ST_IT_VCD,
    ST_IT_TD, ST_IT_VS, ST_IT_VSD, ST_IT_TTD, ST_IT_GD, ST_IT_HT, ST_PBASE,
    ST_YAW, ST_FIN, ST_MUL, ST_MUL_FIX, ST_DIV, ST_AT_START, ST_AT_NORM,
    ST_CORD
  } state_e;

  state_e st_q, ret_q;

  logic signed [17:0] off_x_q, off_y_q, off_z_q;
  logic signed [15:0] trim_p_q, trim_y_q;
  logic [15:0]        drag_k_q;
  logic [14:0]        speed_q;

  logic signed [21:0] crd_x_q, crd_y_q, crd_z_q;
  logic [1:0]         cidx_q;
  logic signed [24:0] lat_q, h_q, r_q;
  logic signed [19:0] tp_q, ty_q;

  logic [63:0]  ma_q, mb_q;
  logic         mneg_q;
  logic [1:0]   mcnt_q;
  logic [127:0] macc_q, prod_q;

  logic [63:0] dq_q;
  logic [31:0] drem_q, dvs_q;
  logic [5:0]  dcnt_q;

  logic signed [47:0] cx_q, cy_q;
  logic signed [21:0] cz_q;
  logic [4:0]         ci_q;
  logic               cvec_q;

  logic signed [41:0] aim_q;
  logic [35:0]        dd_q;
  logic               dsat_q;
  logic [63:0]        u_q, term_q, m_q;
  logic [3:0]         sh_q;
  logic [2:0]         tn_q;
  logic [26:0]        t_q;
  logic signed [25:0] vs_q;
  logic [39:0]        gt_q;
  logic [6:0]         it_q, used_q;
  logic               conv_q;
  logic signed [21:0] pang_q;

  logic               out_valid_q, out_conv_q;
  logic signed [19:0] pitch_q, yaw_q;
  logic [6:0]         out_used_q;

  // coordinate conversion
  logic signed [21:0] crd_sel;
  logic               crd_neg;
  logic [21:0]        crd_mag;
  logic signed [24:0] crd_qs, crd_val;
  logic signed [15:0] trim_sel;
  logic               trim_neg;
  logic [16:0]        trim_mag;
  logic signed [19:0] trim_qs;

  // multiplier and divider
  logic [31:0]  ma_part, mb_part;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [32:0]  drem_sh, dsub;
  logic         dge;

  // CORDIC
  logic signed [47:0] dxs, dys, ax, ay;
  logic signed [21:0] tab;
  logic               cdir;

  // height model and output
  logic signed [40:0] vt;
  logic signed [42:0] ht, dy;
  logic signed [43:0] asum;
  logic signed [41:0] aim_new;
  logic signed [22:0] psum, ysum;
  logic signed [19:0] pitch_sat, yaw_sat;
  logic               load_out;

  always_comb begin
    case (cidx_q)
      2'd0:    crd_sel = crd_x_q;
      2'd1:    crd_sel = crd_y_q;
      default: crd_sel = crd_z_q;
    endcase
    crd_neg  = crd_sel[21];
    crd_mag  = crd_neg ? 22'(-crd_sel) : 22'(crd_sel);
    crd_qs   = $signed({1'b0, prod_q[54:31]});
    crd_val  = crd_neg ? -crd_qs : crd_qs;
    trim_sel = cidx_q[0] ? trim_y_q : trim_p_q;
    trim_neg = trim_sel[15];
    trim_mag = trim_neg ? 17'(-17'(trim_sel)) : 17'(trim_sel);
    trim_qs  = $signed(prod_q[67:48]);
  end

  always_comb begin
    ma_part = mcnt_q[0] ? ma_q[63:32] : ma_q[31:0];
    mb_part = mcnt_q[1] ? mb_q[63:32] : mb_q[31:0];
    pp      = ma_part * mb_part;
    case (mcnt_q)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
    drem_sh = {drem_q, dq_q[63]};
    dge     = drem_sh >= {1'b0, dvs_q};
    dsub    = drem_sh - {1'b0, dvs_q};
  end

  always_comb begin
    dxs  = cy_q >>> ci_q;
    dys  = cx_q >>> ci_q;
    tab  = $signed({5'd0, atan_tab(ci_q)});
    cdir = cvec_q ? !(cy_q > 48'sd0) : !cz_q[21];
    ax   = cx_q[47] ? -cx_q : cx_q;
    ay   = cy_q[47] ? -cy_q : cy_q;
  end

  always_comb begin
    vt   = $signed(prod_q[56:16]);
    ht   = 43'(vt) - $signed({3'd0, gt_q});
    dy   = 43'(h_q) - ht;
    asum = 44'(aim_q) + 44'(dy);
    if (asum > AIM_SAT) begin
      aim_new = 42'(AIM_SAT);
    end else if (asum < -AIM_SAT) begin
      aim_new = 42'(-AIM_SAT);
    end else begin
      aim_new = 42'(asum);
    end
    psum = 23'(tp_q) - 23'(pang_q);
    ysum = 23'(ty_q) - 23'(cz_q);
    if (psum > ANGLE_SAT) begin
      pitch_sat = 20'(ANGLE_SAT);
    end else if (psum < -ANGLE_SAT) begin
      pitch_sat = 20'(-ANGLE_SAT);
    end else begin
      pitch_sat = 20'(psum);
    end
    if (ysum > ANGLE_SAT) begin
      yaw_sat = 20'(ANGLE_SAT);
    end else if (ysum < -ANGLE_SAT) begin
      yaw_sat = 20'(-ANGLE_SAT);
    end else begin
      yaw_sat = 20'(ysum);
    end
    load_out = (st_q == ST_FIN) && (!out_valid_q || out_ready_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE;
      ret_q <= ST_IDLE;
      off_x_q <= '0;
      off_y_q <= '0;
      off_z_q <= '0;
      trim_p_q <= '0;
      trim_y_q <= '0;
      drag_k_q <= '0;
      speed_q <= SPEED_RESET;
      crd_x_q <= '0;
      crd_y_q <= '0;
      crd_z_q <= '0;
      cidx_q <= '0;
      lat_q <= '0;
      h_q <= '0;
      r_q <= '0;
      tp_q <= '0;
      ty_q <= '0;
      ma_q <= '0;
      mb_q <= '0;
      mneg_q <= 1'b0;
      mcnt_q <= '0;
      macc_q <= '0;
      prod_q <= '0;
      dq_q <= '0;
      drem_q <= '0;
      dvs_q <= '0;
      dcnt_q <= '0;
      cx_q <= '0;
      cy_q <= '0;
      cz_q <= '0;
      ci_q <= '0;
      cvec_q <= 1'b0;
      aim_q <= '0;
      dd_q <= '0;
      dsat_q <= 1'b0;
      u_q <= '0;
      term_q <= '0;
      m_q <= '0;
      sh_q <= '0;
      tn_q <= '0;
      t_q <= '0;
      vs_q <= '0;
      gt_q <= '0;
      it_q <= '0;
      used_q <= '0;
      conv_q <= 1'b0;
      pang_q <= '0;
      out_valid_q <= 1'b0;
      out_conv_q <= 1'b0;
      out_used_q <= '0;
      pitch_q <= '0;
      yaw_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_OFFSET_X:   off_x_q <= $signed(cfg_data_i[17:0]);
          REG_OFFSET_Y:   off_y_q <= $signed(cfg_data_i[17:0]);
          REG_OFFSET_Z:   off_z_q <= $signed(cfg_data_i[17:0]);
          REG_PITCH_TRIM: trim_p_q <= $signed(cfg_data_i[15:0]);
          REG_YAW_TRIM:   trim_y_q <= $signed(cfg_data_i[15:0]);
          REG_DRAG_COEFF: drag_k_q <= cfg_data_i[15:0];
          REG_SPEED:      speed_q <= cfg_data_i[14:0];
          default: ;
        endcase
      end

      if (load_out) begin
        out_valid_q <= 1'b1;
        pitch_q <= pitch_sat;
        yaw_q <= yaw_sat;
        out_conv_q <= conv_q;
        out_used_q <= used_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      case (st_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            crd_x_q <= 22'(target_x_i) + 22'(off_x_q);
            crd_y_q <= 22'(target_y_i) + 22'(off_y_q);
            crd_z_q <= 22'(target_z_i) + 22'(off_z_q);
            cidx_q <= 2'd0;
            st_q <= ST_CONV;
          end
        end
        ST_CONV: begin
          ma_q <= 64'(crd_mag);
          mb_q <= MM10_RECIP;
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_CONV_DONE;
          st_q <= ST_MUL;
        end
        ST_CONV_DONE: begin
          case (cidx_q)
            2'd0:    lat_q <= crd_val;
            2'd1:    h_q <= -crd_val;
            default: r_q <= crd_val;
          endcase
          if (cidx_q == 2'd2) begin
            cidx_q <= 2'd0;
            st_q <= ST_TRIM;
          end else begin
            cidx_q <= cidx_q + 2'd1;
            st_q <= ST_CONV;
          end
        end
        ST_TRIM: begin
          ma_q <= 64'(trim_mag);
          mb_q <= TRIM_MUL;
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_TRIM_DIV;
          st_q <= ST_MUL;
        end
        ST_TRIM_DIV: begin
          ma_q <= prod_q[63:0] + TRIM_RND;
          mb_q <= TRIM_RECIP;
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_TRIM_DONE;
          st_q <= ST_MUL;
        end
        ST_TRIM_DONE: begin
          if (cidx_q[0]) begin
            ty_q <= trim_neg ? -trim_qs : trim_qs;
            st_q <= ST_START;
          end else begin
            tp_q <= trim_neg ? -trim_qs : trim_qs;
            cidx_q <= 2'd1;
            st_q <= ST_TRIM;
          end
        end
        ST_START: begin
          aim_q <= 42'(h_q);
          dsat_q <= 1'b0;
          it_q <= '0;
          used_q <= 7'd1;
          conv_q <= 1'b0;
          if (r_q <= 25'sd0) begin
            cx_q <= 48'(r_q);
            cy_q <= 48'(h_q);
            cvec_q <= 1'b1;
            ret_q <= ST_PBASE;
            st_q <= ST_AT_START;
          end else if (drag_k_q == 16'd0) begin
            dd_q <= 36'(r_q);
            st_q <= ST_ITER;
          end else begin
            ma_q <= 64'(drag_k_q);
            mb_q <= 64'(r_q);
            mneg_q <= 1'b0;
            macc_q <= '0;
            mcnt_q <= '0;
            ret_q <= ST_DRAG_U;
            st_q <= ST_MUL;
          end
        end
        ST_DRAG_U: begin
          if (prod_q[63:0] >= U_SAT) begin
            dsat_q <= 1'b1;
            st_q <= ST_ITER;
          end else begin
            u_q <= prod_q[63:0];
            sh_q <= '0;
            st_q <= ST_HALVE;
          end
        end
        ST_HALVE: begin
          if (u_q >= U_HALF) begin
            u_q <= u_q >> 1;
            sh_q <= sh_q + 4'd1;
          end else begin
            term_q <= u_q;
            m_q <= u_q;
            tn_q <= 3'd2;
            st_q <= ST_TAY_MUL;
          end
        end
        ST_TAY_MUL: begin
          ma_q <= term_q;
          mb_q <= u_q;
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_TAY_DIV;
          st_q <= ST_MUL;
        end
        ST_TAY_DIV: begin
          ma_q <= prod_q[95:32];
          mb_q <= tay_recip(tn_q);
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_TAY_ADD;
          st_q <= ST_MUL;
        end
        ST_TAY_ADD: begin
          term_q <= prod_q[95:32];
          m_q <= m_q + prod_q[95:32];
          if (tn_q == 3'd5) begin
            st_q <= ST_SQ;
          end else begin
            tn_q <= tn_q + 3'd1;
            st_q <= ST_TAY_MUL;
          end
        end
        ST_SQ: begin
          if (sh_q == 4'd0) begin
            dq_q <= m_q;
            drem_q <= '0;
            dvs_q <= 32'(drag_k_q);
            dcnt_q <= '0;
            ret_q <= ST_DDIV_DONE;
            st_q <= ST_DIV;
          end else begin
            ma_q <= m_q;
            mb_q <= m_q + TWO_Q32;
            mneg_q <= 1'b0;
            macc_q <= '0;
            mcnt_q <= '0;
            ret_q <= ST_SQ_DONE;
            st_q <= ST_MUL;
          end
        end
        ST_SQ_DONE: begin
          m_q <= prod_q[95:32];
          sh_q <= sh_q - 4'd1;
          st_q <= ST_SQ;
        end
        ST_DDIV_DONE: begin
          if (dq_q >= D_SAT) begin
            dsat_q <= 1'b1;
          end else begin
            dd_q <= dq_q[35:0];
          end
          st_q <= ST_ITER;
        end
        ST_ITER: begin
          cx_q <= 48'(r_q);
          cy_q <= 48'(aim_q);
          cvec_q <= 1'b1;
          ret_q <= ST_IT_SC;
          st_q <= ST_AT_START;
        end
        ST_IT_SC: begin
          pang_q <= cz_q;
          cx_q <= CORDIC_GAIN_Q30;
          cy_q <= '0;
          cvec_q <= 1'b0;
          ci_q <= '0;
          ret_q <= ST_IT_VC;
          st_q <= ST_CORD;
        end
        ST_IT_VC: begin
          ma_q <= 64'(speed_q);
          mb_q <= 64'(ax);
          mneg_q <= cx_q[47];
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_IT_VCD;
          st_q <= ST_MUL;
        end
        ST_IT_VCD: begin
          if (dsat_q || $signed(prod_q[47:14]) <= 34'sd0) begin
            t_q <= T_SAT;
            st_q <= ST_IT_VS;
          end else begin
            dq_q <= {4'd0, dd_q, 24'd0};
            drem_q <= '0;
            dvs_q <= prod_q[45:14];
            dcnt_q <= '0;
            ret_q <= ST_IT_TD;
            st_q <= ST_DIV;
          end
        end
        ST_IT_TD: begin
          t_q <= (dq_q >= 64'(T_SAT)) ? T_SAT : dq_q[26:0];
          st_q <= ST_IT_VS;
        end
        ST_IT_VS: begin
          ma_q <= 64'(speed_q);
          mb_q <= 64'(ay);
          mneg_q <= cy_q[47];
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_IT_VSD;
          st_q <= ST_MUL;
        end
        ST_IT_VSD: begin
          vs_q <= $signed(prod_q[47:22]);
          ma_q <= 64'(t_q);
          mb_q <= 64'(t_q);
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_IT_TTD;
          st_q <= ST_MUL;
        end
        ST_IT_TTD: begin
          ma_q <= GRAV_Q16;
          mb_q <= 64'(prod_q[52:16]);
          mneg_q <= 1'b0;
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_IT_GD;
          st_q <= ST_MUL;
        end
        ST_IT_GD: begin
          gt_q <= prod_q[56:17];
          ma_q <= vs_q[25] ? 64'(-vs_q) : 64'(vs_q);
          mb_q <= 64'(t_q);
          mneg_q <= vs_q[25];
          macc_q <= '0;
          mcnt_q <= '0;
          ret_q <= ST_IT_HT;
          st_q <= ST_MUL;
        end
        ST_IT_HT: begin
          aim_q <= aim_new;
          used_q <= it_q + 7'd1;
          if (dy >= -TOL_Q16 && dy <= TOL_Q16) begin
            conv_q <= 1'b1;
            st_q <= ST_YAW;
          end else if (it_q == 7'(MAX_ITERATIONS - 1)) begin
            st_q <= ST_YAW;
          end else begin
            it_q <= it_q + 7'd1;
            st_q <= ST_ITER;
          end
        end
        ST_PBASE: begin
          pang_q <= cz_q;
          st_q <= ST_YAW;
        end
        ST_YAW: begin
          cx_q <= 48'(r_q);
          cy_q <= 48'(lat_q);
          cvec_q <= 1'b1;
          ret_q <= ST_FIN;
          st_q <= ST_AT_START;
        end
        ST_FIN: begin
          if (load_out) begin
            st_q <= ST_IDLE;
          end
        end
        ST_MUL: begin
          macc_q <= macc_q + pp_sh;
          mcnt_q <= mcnt_q + 2'd1;
          if (mcnt_q == 2'd3) begin
            st_q <= ST_MUL_FIX;
          end
        end
        ST_MUL_FIX: begin
          prod_q <= mneg_q ? -macc_q : macc_q;
          st_q <= ret_q;
        end
        ST_DIV: begin
          dq_q <= {dq_q[62:0], dge};
          drem_q <= dge ? dsub[31:0] : drem_sh[31:0];
          dcnt_q <= dcnt_q + 6'd1;
          if (dcnt_q == 6'd63) begin
            st_q <= ret_q;
          end
        end
        ST_AT_START: begin
          cz_q <= '0;
          if (cx_q == 48'sd0 && cy_q == 48'sd0) begin
            st_q <= ret_q;
          end else begin
            st_q <= ST_AT_NORM;
          end
        end
        ST_AT_NORM: begin
          if (ax < $signed(NORM_MIN) && ay < $signed(NORM_MIN)) begin
            cx_q <= cx_q <<< 1;
            cy_q <= cy_q <<< 1;
          end else begin
            if (cx_q[47]) begin
              if (!cy_q[47]) begin
                cx_q <= cy_q;
                cy_q <= -cx_q;
                cz_q <= HALF_PI_Q16;
              end else begin
                cx_q <= -cy_q;
                cy_q <= cx_q;
                cz_q <= -HALF_PI_Q16;
              end
            end
            ci_q <= '0;
            st_q <= ST_CORD;
          end
        end
        ST_CORD: begin
          if (cdir) begin
            cx_q <= cx_q - dxs;
            cy_q <= cy_q + dys;
            cz_q <= cz_q - tab;
          end else begin
            cx_q <= cx_q + dxs;
            cy_q <= cy_q - dys;
            cz_q <= cz_q + tab;
          end
          if (ci_q == CORDIC_LAST) begin
            st_q <= ret_q;
          end else begin
            ci_q <= ci_q + 5'd1;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  assign in_ready_o        = (st_q == ST_IDLE);
  assign cfg_ready_o       = 1'b1;
  assign out_valid_o       = out_valid_q;
  assign pitch_angle_o     = pitch_q;
  assign yaw_angle_o       = yaw_q;
  assign converged_o       = out_conv_q;
  assign iterations_used_o = out_used_q;

  a_used_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (iterations_used_o >= 7'd1 &&
                     iterations_used_o <= 7'(MAX_ITERATIONS)))
    else $error("iteration count out of range");

  a_no_conv_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !converged_o) |->
      (iterations_used_o == 7'(MAX_ITERATIONS) || iterations_used_o == 7'd1))
    else $error("unconverged result stopped early");

  a_div_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_DIV) |-> (dvs_q != 32'd0))
    else $error("divide by zero");

  a_cordic_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q == ST_CORD) |-> (ci_q <= CORDIC_LAST))
    else $error("CORDIC step index overrun");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second beat taken while busy");

endmodule
`default_nettype wire

FILE: tb/aim_solution_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aim_solution_checker
// Watches the target, solution and register channels of the aim solver,
// computes the expected pitch, yaw, convergence flag and iteration count for
// every accepted target, and compares each solution beat in order.
// ----------------------------------------------------------------------------
module aim_solution_checker #(
  parameter int unsigned MAX_ITERATIONS = 20
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic signed [20:0] target_x_i,
  input  logic signed [20:0] target_y_i,
  input  logic signed [20:0] target_z_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [19:0] pitch_angle_i,
  input  logic signed [19:0] yaw_angle_i,
  input  logic               converged_i,
  input  logic [6:0]         iterations_used_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [2:0]         cfg_index_i,
  input  logic [17:0]        cfg_data_i,
  output int                 errors_o,
  output int                 pending_o
);
  import bdas_pkg::*;

  localparam longint HalfPi = 102944;
  localparam longint Gain = 652032874;
  localparam longint Gravity = 640942;
  localparam longint TimeLimit = 64'sd1 << 26;
  localparam longint AimLimit = 64'sd1 << 40;
  localparam longint AngleLimit = 411775;
  localparam longint HeightTol = 65;
  localparam longint ArcTab [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024,
                                     512, 256, 128, 64, 32, 16, 8, 4, 2, 1};

  typedef struct packed {
    logic [19:0] pitch;
    logic [19:0] yaw;
    logic        conv;
    logic [6:0]  iters;
  } solution_t;

  solution_t solution_q[$];
  longint mount_x, mount_y, mount_z, pitch_trim, yaw_trim;
  longint unsigned drag_k, muzzle_v;

  function automatic longint mag(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic longint clamp(longint v, longint lim);
    return v > lim ? lim : (v < -lim ? -lim : v);
  endfunction

  function automatic longint mm10_to_q16(longint d);
    return d * 4096 / 625;
  endfunction

  function automatic longint cdeg_to_rad(longint c);
    longint n;
    n = c * 205887;
    return (n >= 0 ? n + 9000 : n - 9000) / 18000;
  endfunction

  function automatic longint unsigned mul_q32(longint unsigned a, longint unsigned b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[95:32];
  endfunction

  function automatic longint arctan2(longint y, longint x);
    longint ang, t, dx, dy;
    ang = 0;
    if (x == 0 && y == 0) return 0;
    while ((mag(x) > mag(y) ? mag(x) : mag(y)) < (64'sd1 << 40)) begin
      x = x * 2;
      y = y * 2;
    end
    if (x < 0) begin
      if (y >= 0) begin
        t = x; x = y; y = -t; ang = HalfPi;
      end else begin
        t = x; x = -y; y = t; ang = -HalfPi;
      end
    end
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y > 0) begin
        x += dx; y -= dy; ang += ArcTab[i];
      end else begin
        x -= dx; y += dy; ang -= ArcTab[i];
      end
    end
    return ang;
  endfunction

  function automatic void sin_cos(longint a, output longint s, output longint c);
    longint x, y, z, dx, dy;
    x = Gain;
    y = 0;
    z = a;
    for (int i = 0; i < 17; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ArcTab[i];
      end else begin
        x += dx; y -= dy; z += ArcTab[i];
      end
    end
    s = y;
    c = x;
  endfunction

  function automatic bit drag_span(longint r, output longint unsigned d);
    longint unsigned u, term, m;
    int sh;
    d = 0;
    if (drag_k == 0) begin
      d = longint'(r);
      return 1;
    end
    u = drag_k * longint'(r);
    if (u >= (64'd14 << 32)) return 0;
    sh = 0;
    while (u >= (64'd1 << 28)) begin
      u = u >> 1;
      sh++;
    end
    term = u;
    m = u;
    for (int n = 2; n <= 5; n++) begin
      term = mul_q32(term, u) / n;
      m += term;
    end
    repeat (sh) m = mul_q32(m, m + (64'd2 << 32));
    m = m / drag_k;
    if (m >= (64'd1 << 36)) return 0;
    d = m;
    return 1;
  endfunction

  function automatic longint drop_height(longint r, longint a);
    longint sn, cs, vc, t, vs, t2;
    longint unsigned d, q;
    bit ok;
    sin_cos(a, sn, cs);
    vc = (longint'(muzzle_v) * cs) >>> 14;
    ok = drag_span(r, d);
    if (!ok || vc <= 0) begin
      t = TimeLimit;
    end else begin
      q = (d << 24) / longint'(vc);
      t = q >= TimeLimit ? TimeLimit : longint'(q);
    end
    vs = (longint'(muzzle_v) * sn) >>> 22;
    t2 = (t * t) >>> 16;
    return ((vs * t) >>> 16) - ((Gravity * t2) >>> 17);
  endfunction

  function automatic solution_t solve_aim(logic signed [20:0] tx, logic signed [20:0] ty,
                                         logic signed [20:0] tz);
    longint lat, h, r, a, aim, dy, pitch, yaw;
    solution_t s;
    s.conv = 1'b0;
    s.iters = 7'd1;
    lat = mm10_to_q16(longint'(tx) + mount_x);
    h = -mm10_to_q16(longint'(ty) + mount_y);
    r = mm10_to_q16(longint'(tz) + mount_z);
    a = 0;
    aim = h;
    if (r <= 0) begin
      a = arctan2(h, r);
    end else begin
      for (int i = 0; i < MAX_ITERATIONS; i++) begin
        a = arctan2(aim, r);
        dy = h - drop_height(r, a);
        aim = clamp(aim + dy, AimLimit);
        s.iters = 7'(i + 1);
        if (mag(dy) <= HeightTol) begin
          s.conv = 1'b1;
          break;
        end
      end
    end
    pitch = clamp(-a + cdeg_to_rad(pitch_trim), AngleLimit);
    yaw = clamp(-arctan2(lat, r) + cdeg_to_rad(yaw_trim), AngleLimit);
    s.pitch = 20'(pitch);
    s.yaw = 20'(yaw);
    return s;
  endfunction

  assign pending_o = solution_q.size();

  always @(posedge clk_i or negedge rst_ni) begin : watch
    solution_t exp_s;
    if (!rst_ni) begin
      mount_x = 0; mount_y = 0; mount_z = 0;
      pitch_trim = 0; yaw_trim = 0;
      drag_k = 0;
      muzzle_v = 3840;
      errors_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          REG_OFFSET_X:   mount_x = longint'($signed(cfg_data_i));
          REG_OFFSET_Y:   mount_y = longint'($signed(cfg_data_i));
          REG_OFFSET_Z:   mount_z = longint'($signed(cfg_data_i));
          REG_PITCH_TRIM: pitch_trim = longint'($signed(cfg_data_i[15:0]));
          REG_YAW_TRIM:   yaw_trim = longint'($signed(cfg_data_i[15:0]));
          REG_DRAG_COEFF: drag_k = cfg_data_i[15:0];
          REG_SPEED:      muzzle_v = cfg_data_i[14:0];
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i)
        solution_q.push_back(solve_aim(target_x_i, target_y_i, target_z_i));
      if (out_valid_i && out_ready_i) begin
        if (solution_q.size() == 0) begin
          $display("%0t: solution beat with none expected: pitch %0d yaw %0d", $time,
                   pitch_angle_i, yaw_angle_i);
          errors_o++;
        end else begin
          exp_s = solution_q.pop_front();
          if (pitch_angle_i !== exp_s.pitch) begin
            $display("%0t: pitch expected %0d actual %0d", $time,
                     $signed(exp_s.pitch), pitch_angle_i);
            errors_o++;
          end
          if (yaw_angle_i !== exp_s.yaw) begin
            $display("%0t: yaw expected %0d actual %0d", $time,
                     $signed(exp_s.yaw), yaw_angle_i);
            errors_o++;
          end
          if (converged_i !== exp_s.conv) begin
            $display("%0t: converged expected %0d actual %0d", $time, exp_s.conv,
                     converged_i);
            errors_o++;
          end
          if (iterations_used_i !== exp_s.iters) begin
            $display("%0t: iterations expected %0d actual %0d", $time, exp_s.iters,
                     iterations_used_i);
            errors_o++;
          end
        end
      end
    end
  end

endmodule

FILE: tb/tb_ballistic_drag_aim_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ballistic_drag_aim_solver
// Drives targets and register writes into the aim solver with random gaps and
// back-pressure, across several mount, trim, drag and speed settings; the
// checker predicts and compares every solution.
// ----------------------------------------------------------------------------
module tb_ballistic_drag_aim_solver;
  import bdas_pkg::*;

  localparam longint CycleLimit = 30000000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [20:0] target_x_i = '0;
  logic signed [20:0] target_y_i = '0;
  logic signed [20:0] target_z_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [19:0] pitch_angle_o;
  logic signed [19:0] yaw_angle_o;
  logic               converged_o;
  logic [6:0]         iterations_used_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [2:0]         cfg_index_i = '0;
  logic [17:0]        cfg_data_i = '0;
  int                 errors;
  int                 pending;
  bit                 no_idle = 1'b0;
  bit                 long_hold = 1'b0;
  longint             cycles = 0;

  ballistic_drag_aim_solver dut (.*);

  aim_solution_checker chk (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o),
    .target_x_i, .target_y_i, .target_z_i,
    .out_valid_i(out_valid_o), .out_ready_i,
    .pitch_angle_i(pitch_angle_o), .yaw_angle_i(yaw_angle_o),
    .converged_i(converged_o), .iterations_used_i(iterations_used_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  always #10 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("tb_ballistic_drag_aim_solver: done, errors");
      $finish;
    end
  end

  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold) begin
        out_ready_i <= 1'b0;
        repeat (20000) @(posedge clk_i);
        long_hold = 1'b0;
      end else begin
        out_ready_i <= no_idle || ($urandom_range(99) >= 13);
      end
    end
  end

  task automatic send_target(int x, int y, int z);
    if (!no_idle && $urandom_range(99) < 13) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    target_x_i <= 21'(x);
    target_y_i <= 21'(y);
    target_z_i <= 21'(z);
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, int val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= 18'(val);
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_regs(int ox, int oy, int oz, int tp, int ty, int k, int v);
    write_reg(REG_OFFSET_X, ox);
    write_reg(REG_OFFSET_Y, oy);
    write_reg(REG_OFFSET_Z, oz);
    write_reg(REG_PITCH_TRIM, tp);
    write_reg(REG_YAW_TRIM, ty);
    write_reg(REG_DRAG_COEFF, k);
    write_reg(REG_SPEED, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic random_target();
    int pick;
    pick = $urandom_range(99);
    if (pick < 70)
      send_target($urandom_range(40000) - 20000, $urandom_range(40000) - 20000,
                  $urandom_range(80000, 3000));
    else if (pick < 85)
      send_target($urandom_range(2000000) - 1000000, $urandom_range(2000000) - 1000000,
                  $urandom_range(2000000) - 1000000);
    else
      send_target($urandom_range(40000) - 20000, $urandom_range(40000) - 20000,
                  -$urandom_range(120000));
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_target(0, 0, 0);
    send_target(0, 0, 50000);
    send_target(0, -20000, 50000);
    send_target(10000, 5000, 30000);
    send_target(1000000, 1000000, 1000000);
    send_target(-1000000, -1000000, 1000000);
    send_target(1000000, -1000000, -1000000);
    send_target(-1000000, 1000000, -1000000);
    send_target(0, -1000000, 10000);
    send_target(0, 1000000, 1);
    send_target(5000, 0, 0);
    send_target(-5000, 3000, -40000);
    send_target(0, 0, 1000000);
    drain();
    set_regs(100000, 100000, 100000, 18000, 18000, 65535, 256);
    send_target(0, 0, 50000);
    send_target(-1000000, -1000000, -1000000);
    send_target(1000000, 1000000, 1000000);
    send_target(0, 0, -100000);
    drain();
    set_regs(-100000, -100000, -100000, -18000, -18000, 0, 25600);
    send_target(0, 0, 50000);
    send_target(1000000, 1000000, 1000000);
    send_target(0, 0, 100000);
    send_target(20000, -20000, 200000);

    for (int phase = 0; phase < 6; phase++) begin
      drain();
      case (phase)
        0: set_regs(0, 0, 0, 0, 0, 3000, 3840);
        1: set_regs(100000, 100000, 100000, 18000, 18000, 65535, 256);
        2: set_regs(-100000, -100000, -100000, -18000, -18000, 0, 25600);
        default: set_regs($urandom_range(200000) - 100000, $urandom_range(200000) - 100000,
                          $urandom_range(200000) - 100000, $urandom_range(36000) - 18000,
                          $urandom_range(36000) - 18000, $urandom_range(65535),
                          $urandom_range(25600, 256));
      endcase
      no_idle = (phase == 3);
      if (phase == 2) long_hold = 1'b1;
      repeat (46) random_target();
    end
    no_idle = 1'b0;

    drain();
    if (errors == 0)
      $display("tb_ballistic_drag_aim_solver: done, clean");
    else
      $display("tb_ballistic_drag_aim_solver: done, errors");
    $finish;
  end

endmodule
